/* rtl/srp_pkg.sv */
// Shared types and constants for the S-record line parser.
package srp_pkg;

  localparam logic [7:0] CharS  = 8'h53;
  localparam logic [7:0] CharCr = 8'h0D;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_DONE   = 3'd1;
  localparam logic [2:0] KIND_HEADER = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_BAD    = 3'd4;

  typedef struct packed {
    logic       is_cr;
    logic       is_s;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_hex;
    logic [3:0] hex;
  } char_class_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [7:0]  record_length;
    logic [3:0]  record_kind;
    logic [31:0] total_bytes;
  } result_t;

endpackage

/* rtl/srp_char_class.sv */
// Character classifier: record markers, decimal digits and hex digits.
module srp_char_class
  import srp_pkg::*;
(
  input  logic [7:0]  char_i,
  output char_class_t cls_o
);

  always_comb begin
    cls_o          = '0;
    cls_o.is_cr    = (char_i == CharCr);
    cls_o.is_s     = (char_i == CharS);
    cls_o.is_digit = char_i inside {[8'h30:8'h39]};
    cls_o.digit    = char_i[3:0];
    if (char_i inside {[8'h30:8'h39]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.hex    = char_i[3:0];
    end else if (char_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      // 'A'..'F' and 'a'..'f' share the low three bits: 1..6
      cls_o.is_hex = 1'b1;
      cls_o.hex    = char_i[3:0] + 4'd9;
    end
  end

endmodule

/* rtl/srp_parse_core.sv */
// Record state machine: decodes fields and forms at most one result per transaction.
module srp_parse_core
  import srp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_TAIL  = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  char_class_t cls;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] addr_q, addr_d;
  logic [3:0]  high_q, high_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  index_q, index_d;
  logic [31:0] total_q, total_d;
  logic        bad_q, bad_d;

  logic [7:0]  count_next;
  logic [7:0]  needed;
  logic [7:0]  needed_next;

  srp_char_class u_char_class (
    .char_i (char_i),
    .cls_o  (cls)
  );

  assign count_next  = {count_q[3:0], cls.hex};
  // address bytes are type + 1, plus one checksum byte
  assign needed      = count_q - {4'b0, type_q} - 8'd2;
  assign needed_next = needed;

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    count_d     = count_q;
    addr_d      = addr_q;
    high_d      = high_q;
    pos_d       = pos_q;
    index_d     = index_q;
    total_d     = total_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o             = '0;
    res_o.record_kind = type_q;

    if (accept_i) begin
      if (cls.is_cr) begin
        res_valid_o = 1'b1;
        if (bad_q) begin
          res_o.kind = KIND_BAD;
        end else if (phase_q == PH_SKIP && type_q == 4'd0) begin
          res_o.kind = KIND_HEADER;
        end else if (phase_q == PH_SKIP && type_q == 4'd7) begin
          res_o.kind        = KIND_END;
          res_o.total_bytes = total_q;
        end else if (phase_q == PH_TAIL) begin
          res_o.kind          = KIND_DONE;
          res_o.record_length = index_q;
          total_d             = total_q + {24'b0, index_q};
        end else begin
          res_o.kind = KIND_BAD;
        end
        phase_d = PH_START;
        type_d  = '0;
        count_d = '0;
        addr_d  = '0;
        high_d  = '0;
        pos_d   = '0;
        index_d = '0;
        bad_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_START: begin
            if (cls.is_s) begin
              phase_d = PH_TYPE;
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_SKIP;
            end
          end
          PH_TYPE: begin
            if (cls.is_digit) begin
              type_d = cls.digit;
              if (cls.digit == 4'd0 || cls.digit == 4'd7) begin
                phase_d = PH_SKIP;
              end else if (cls.digit inside {[4'd1:4'd3]}) begin
                phase_d = PH_COUNT;
              end else begin
                bad_d   = 1'b1;
                phase_d = PH_SKIP;
              end
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_SKIP;
            end
          end
          PH_TAIL, PH_SKIP: begin
          end
          default: begin
            if (!cls.is_hex) begin
              bad_d   = 1'b1;
              phase_d = PH_SKIP;
            end else if (phase_q == PH_COUNT) begin
              count_d = count_next;
              if (pos_q == 3'd1) begin
                pos_d = '0;
                if (count_next < {4'b0, type_q} + 8'd2) begin
                  bad_d   = 1'b1;
                  phase_d = PH_SKIP;
                end else begin
                  phase_d = PH_ADDR;
                end
              end else begin
                pos_d = pos_q + 3'd1;
              end
            end else if (phase_q == PH_ADDR) begin
              addr_d = {addr_q[27:0], cls.hex};
              if ({1'b0, pos_q} + 4'd1 == {type_q[2:0], 1'b0} + 4'd2) begin
                pos_d   = '0;
                phase_d = (needed_next == 8'd0) ? PH_TAIL : PH_DATA;
              end else begin
                pos_d = pos_q + 3'd1;
              end
            end else if (phase_q == PH_DATA) begin
              if (pos_q == 3'd0) begin
                high_d = cls.hex;
                pos_d  = 3'd1;
              end else begin
                res_valid_o        = 1'b1;
                res_o.kind         = KIND_DATA;
                res_o.data_byte    = {high_q, cls.hex};
                res_o.byte_address = addr_q + {24'b0, index_q};
                pos_d              = '0;
                index_d            = index_q + 8'd1;
                if ({1'b0, index_q} + 9'd1 >= {1'b0, needed}) begin
                  phase_d = PH_TAIL;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      type_q  <= '0;
      count_q <= '0;
      addr_q  <= '0;
      high_q  <= '0;
      pos_q   <= '0;
      index_q <= '0;
      total_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      high_q  <= high_d;
      pos_q   <= pos_d;
      index_q <= index_d;
      total_q <= total_d;
      bad_q   <= bad_d;
    end
  end

endmodule

/* rtl/srp_out_buf.sv */
// Two-entry output register with skid slot for result transactions.
module srp_out_buf
  import srp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

/* rtl/srecord_line_parser.sv */
// Top level of the S-record line parser.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o  | char_in_i
//   out     | output    | out_valid_o / out_stall_i | kind_o, data_byte_o,
//           |           |                        | byte_address_o, record_length_o,
//           |           |                        | record_kind_o, total_bytes_o
//
// One character per cycle while in_stall_o is low; results are registered.
// The record state machine updates in the cycle of the transaction.
// in_stall_o rises only when both output slots hold unread results.
// Reset clears the record state, the running total and both output slots.
module srecord_line_parser
  import srp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] byte_address_o,
  output logic [7:0]  record_length_o,
  output logic [3:0]  record_kind_o,
  output logic [31:0] total_bytes_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  srp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_i      (char_in_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o          = out_data.kind;
  assign data_byte_o     = out_data.data_byte;
  assign byte_address_o  = out_data.byte_address;
  assign record_length_o = out_data.record_length;
  assign record_kind_o   = out_data.record_kind;
  assign total_bytes_o   = out_data.total_bytes;

endmodule
